### rtl/mwcs_pkg.sv
package mwcs_pkg;

    // Number of component images that enter the model sum.
    localparam int COMPONENTS = 4;
    // Number of weight registers and component ports.
    localparam int NUM_WEIGHTS = 4;

    localparam int PIX_W     = 24;
    localparam int WEIGHT_W  = 24;
    localparam int CFG_IDX_W = 8;
    localparam int CHI_W     = 63;

    // Model sum and numerator magnitude fit in 50 bits (Q.16).
    localparam int MODEL_W = 50;
    localparam int HALF_W  = MODEL_W / 2;
    // Multiplier operand and product widths.
    localparam int MUL_W  = 27;
    localparam int PROD_W = 2 * MUL_W;
    // Divisor is the denominator shifted left by 8.
    localparam int DEN_W = MODEL_W + 8;
    // Square of the numerator magnitude.
    localparam int SQ_W = 2 * MODEL_W;
    // Quotient bits produced by the divider.
    localparam int QUO_W = CHI_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 6;
    localparam int CIDX_W      = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(65536);
    localparam logic [CHI_W-1:0]    CHI_MAX      = {CHI_W{1'b1}};

    typedef logic signed [PIX_W-1:0] t_pixel;
    typedef logic [WEIGHT_W-1:0]     t_weight;

    typedef struct packed {
        logic [NUM_WEIGHTS-1:0][PIX_W-1:0] comp;
        logic [PIX_W-1:0]                  ref_px;
        logic                              last;
        logic                              masked;
    } t_item;

endpackage

### rtl/masked_weighted_chi_square.sv
// Masked weighted chi-square accumulator.
// The input channel (i_valid/o_ready) carries one pixel per transaction: the
// reference pixel, one pixel of each of the four component images and a
// last-pixel mark. Unmasked pixels (nonzero reference) add
// (ref - model)^2 / (|ref| + model) to a running sum, where the model is the
// weighted sum of the component pixels. The weights are written through the
// configuration channel (i_cfg_valid/o_cfg_ready, index 0 to 3); the user must
// write them only while the block is idle, which the block does not enforce.
// Writes to other indexes are ignored. On a pixel marked last, one result
// transaction leaves on the output channel (o_valid/i_ready) with the saturated
// sum and two flags, and the sum clears. An unmasked pixel passes through the
// back end in order: taking it from the queue, the four weight products on the
// shared multiplier, the denominator, the square, a range check, the bit-serial
// divider steps, adding the term and finishing. A term that saturates skips the
// divider; a nonpositive denominator and a masked pixel go straight to the
// finish. A two-entry queue sits between the input and the back end.
// The result waits in an output register; a stalled receiver holds the back
// end only when the next result is ready to leave. Reset clears the queue, the
// sum, the flags and the output valid, and restores all weights to 1.0.
module masked_weighted_chi_square (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mwcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  mwcs_pkg::t_weight                 i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  mwcs_pkg::t_pixel                  i_ref_pixel,
    input  mwcs_pkg::t_pixel                  i_comp_pixel_0,
    input  mwcs_pkg::t_pixel                  i_comp_pixel_1,
    input  mwcs_pkg::t_pixel                  i_comp_pixel_2,
    input  mwcs_pkg::t_pixel                  i_comp_pixel_3,
    input  logic                              i_last_pixel,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mwcs_pkg::CHI_W-1:0]        o_chi_square,
    output logic                              o_had_invalid,
    output logic                              o_saturated
);
    import mwcs_pkg::*;

    t_item w_item;
    logic  w_item_valid;
    logic  w_pop;

    // Weight writes are always taken at once.
    assign o_cfg_ready = 1'b1;

    // Front end: classifies each pixel and holds it in the queue.
    mwcs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_ref_pixel    (i_ref_pixel),
        .i_comp_pixel_0 (i_comp_pixel_0),
        .i_comp_pixel_1 (i_comp_pixel_1),
        .i_comp_pixel_2 (i_comp_pixel_2),
        .i_comp_pixel_3 (i_comp_pixel_3),
        .i_last_pixel   (i_last_pixel),
        .o_item         (w_item),
        .o_item_valid   (w_item_valid),
        .i_pop          (w_pop)
    );

    // Back end: the arithmetic sequencer, the running sum and the output register.
    mwcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_item        (w_item),
        .i_item_valid  (w_item_valid),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_chi_square  (o_chi_square),
        .o_had_invalid (o_had_invalid),
        .o_saturated   (o_saturated)
    );

endmodule

### rtl/mwcs_front.sv
module mwcs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  mwcs_pkg::t_pixel      i_ref_pixel,
    input  mwcs_pkg::t_pixel      i_comp_pixel_0,
    input  mwcs_pkg::t_pixel      i_comp_pixel_1,
    input  mwcs_pkg::t_pixel      i_comp_pixel_2,
    input  mwcs_pkg::t_pixel      i_comp_pixel_3,
    input  logic                  i_last_pixel,
    output mwcs_pkg::t_item       o_item,
    output logic                  o_item_valid,
    input  logic                  i_pop
);
    import mwcs_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    t_item               w_item;
    logic                w_push;
    logic                w_pop;

    // Classify the pixel on entry: a zero reference marks it as masked.
    always_comb begin
        w_item.ref_px  = i_ref_pixel;
        w_item.comp[0] = i_comp_pixel_0;
        w_item.comp[1] = i_comp_pixel_1;
        w_item.comp[2] = i_comp_pixel_2;
        w_item.comp[3] = i_comp_pixel_3;
        w_item.last    = i_last_pixel;
        w_item.masked  = (i_ref_pixel == '0);
    end

    assign o_ready      = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/mwcs_back.sv
module mwcs_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [mwcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  mwcs_pkg::t_weight                 i_cfg_data,
    input  mwcs_pkg::t_item                   i_item,
    input  logic                              i_item_valid,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mwcs_pkg::CHI_W-1:0]        o_chi_square,
    output logic                              o_had_invalid,
    output logic                              o_saturated
);
    import mwcs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_DEN  = 8'b0000_0100,
        S_SQ   = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state                     r_state;
    t_weight                    r_weight [NUM_WEIGHTS];
    t_item                      r_item;
    logic [CNT_W-1:0]           r_cnt;
    logic signed [MODEL_W-1:0]  r_model;
    logic signed [PROD_W-1:0]   r_prod;
    logic [MODEL_W-1:0]         r_mag;
    logic [DEN_W-1:0]           r_den;
    logic [SQ_W-1:0]            r_sq;
    logic [DEN_W-1:0]           r_rem;
    logic [QUO_W-1:0]           r_qsh;
    logic                       r_tsat;
    logic [CHI_W-1:0]           r_accum;
    logic                       r_inv;
    logic                       r_sat;
    logic                       r_out_valid;
    logic [CHI_W-1:0]           r_out_chi;
    logic                       r_out_inv;
    logic                       r_out_sat;

    logic signed [MUL_W-1:0]    w_mul_a;
    logic signed [MUL_W-1:0]    w_mul_b;
    logic signed [MODEL_W:0]    w_ref24;
    logic signed [MODEL_W:0]    w_abs24;
    logic signed [MODEL_W:0]    w_den;
    logic signed [MODEL_W:0]    w_num;
    logic [SQ_W-1:0]            w_sq_add;
    logic [DEN_W:0]             w_trial;
    logic                       w_qbit;
    logic [CHI_W:0]             w_sum;
    logic [CIDX_W-1:0]          w_cidx;
    logic                       w_emit;

    assign w_cidx = r_cnt[CIDX_W-1:0];

    // One shared signed multiplier serves the model products and the square.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        if (r_state == S_MUL) begin
            w_mul_a = $signed({{(MUL_W - WEIGHT_W){1'b0}}, r_weight[w_cidx]});
            w_mul_b = $signed({{(MUL_W - PIX_W){r_item.comp[w_cidx][PIX_W-1]}},
                               r_item.comp[w_cidx]});
        end else if (r_state == S_SQ) begin
            w_mul_a = $signed({{(MUL_W - HALF_W){1'b0}},
                               (r_cnt == CNT_W'(2)) ? r_mag[MODEL_W-1:HALF_W]
                                                    : r_mag[HALF_W-1:0]});
            w_mul_b = $signed({{(MUL_W - HALF_W){1'b0}},
                               (r_cnt == CNT_W'(0)) ? r_mag[HALF_W-1:0]
                                                    : r_mag[MODEL_W-1:HALF_W]});
        end
    end

    // Reference scaled to Q.16, then numerator and denominator.
    always_comb begin
        w_ref24 = $signed({{(MODEL_W + 1 - PIX_W - 16){r_item.ref_px[PIX_W-1]}},
                           r_item.ref_px, 16'b0});
        w_abs24 = w_ref24[MODEL_W] ? -w_ref24 : w_ref24;
        w_den   = w_abs24 + {r_model[MODEL_W-1], r_model};
        w_num   = w_ref24 - {r_model[MODEL_W-1], r_model};
    end

    // Partial products of the square: low, twice the cross term, high.
    always_comb begin
        unique case (r_cnt)
            CNT_W'(1): w_sq_add = {{(SQ_W - MODEL_W){1'b0}}, r_prod[MODEL_W-1:0]};
            CNT_W'(2): w_sq_add = {{(SQ_W - MODEL_W){1'b0}}, r_prod[MODEL_W-1:0]}
                                  << (HALF_W + 1);
            CNT_W'(3): w_sq_add = {{(SQ_W - MODEL_W){1'b0}}, r_prod[MODEL_W-1:0]}
                                  << MODEL_W;
            default:   w_sq_add = '0;
        endcase
    end

    assign w_trial = {r_rem, r_qsh[QUO_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});
    assign w_sum   = {1'b0, r_accum} + {1'b0, r_qsh};
    assign w_emit  = (r_state == S_FIN) && r_item.last && (!r_out_valid || i_ready);

    assign o_pop         = (r_state == S_IDLE) && i_item_valid;
    assign o_valid       = r_out_valid;
    assign o_chi_square  = r_out_chi;
    assign o_had_invalid = r_out_inv;
    assign o_saturated   = r_out_sat;

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                r_weight[i] <= WEIGHT_RESET;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_WEIGHTS))) begin
            r_weight[i_cfg_index[CIDX_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_accum     <= '0;
            r_inv       <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item  <= i_item;
                        r_model <= '0;
                        r_cnt   <= '0;
                        r_state <= i_item.masked ? S_FIN : S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_cnt != '0) begin
                        r_model <= r_model + r_prod[MODEL_W-1:0];
                    end
                    if (r_cnt == CNT_W'(COMPONENTS)) begin
                        r_state <= S_DEN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DEN: begin
                    r_tsat <= 1'b0;
                    r_sq   <= '0;
                    r_cnt  <= '0;
                    if (w_den[MODEL_W] || (w_den == '0)) begin
                        r_inv   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_den   <= {w_den[MODEL_W-1:0], 8'b0};
                        r_mag   <= w_num[MODEL_W] ? MODEL_W'(-w_num) : w_num[MODEL_W-1:0];
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq <= r_sq + w_sq_add;
                    if (r_cnt == CNT_W'(3)) begin
                        r_state <= S_CHK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CHK: begin
                    // A quotient of 2^63 or more cannot be held: saturate the term.
                    r_cnt <= '0;
                    if ({{(DEN_W - (SQ_W - QUO_W)){1'b0}}, r_sq[SQ_W-1:QUO_W]} >= r_den) begin
                        r_qsh   <= CHI_MAX;
                        r_tsat  <= 1'b1;
                        r_state <= S_ACC;
                    end else begin
                        r_rem   <= {{(DEN_W - (SQ_W - QUO_W)){1'b0}}, r_sq[SQ_W-1:QUO_W]};
                        r_qsh   <= r_sq[QUO_W-1:0];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_qbit ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
                    r_qsh <= {r_qsh[QUO_W-2:0], w_qbit};
                    if (r_cnt == CNT_W'(QUO_W - 1)) begin
                        r_state <= S_ACC;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ACC: begin
                    if (w_sum[CHI_W]) begin
                        r_accum <= CHI_MAX;
                        r_sat   <= 1'b1;
                    end else begin
                        r_accum <= w_sum[CHI_W-1:0];
                        if (r_tsat) begin
                            r_sat <= 1'b1;
                        end
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_item.last) begin
                        r_state <= S_IDLE;
                    end else if (w_emit) begin
                        r_out_chi <= r_accum;
                        r_out_inv <= r_inv;
                        r_out_sat <= r_sat;
                        r_accum   <= '0;
                        r_inv     <= 1'b0;
                        r_sat     <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
